@@ hw/rtl/qrev_pkg.sv @@
// ----------------------------------------------------------------------------
// qrev_pkg
// Shared command, status and state codes of the linear queue with reverse.
// ----------------------------------------------------------------------------
`default_nettype none

package qrev_pkg;

  localparam int unsigned WORD_W = 32;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_REVERSE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_REV_LOAD,
    S_REV_STORE
  } state_e;

  typedef struct packed {
    logic               valid;
    logic [WORD_W-1:0]  value;
    status_e            status;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/qrev_ram.sv @@
// ----------------------------------------------------------------------------
// qrev_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module qrev_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/qrev_ctrl.sv @@
// ----------------------------------------------------------------------------
// qrev_ctrl
// Queue sequencer: head/tail indices, command decode and the two-pass
// reverse copy through the scratch memory.
// ----------------------------------------------------------------------------
`default_nettype none

module qrev_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 128,
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic [1:0]                   in_cmd_i,
  input  wire logic [qrev_pkg::WORD_W-1:0]  in_value_i,
  input  wire logic                         out_free_i,
  output      qrev_pkg::res_t               res_o,
  output      logic                         ent_we_o,
  output      logic [AW-1:0]                ent_waddr_o,
  output      logic [qrev_pkg::WORD_W-1:0]  ent_wdata_o,
  output      logic [AW-1:0]                ent_raddr_o,
  input  wire logic [qrev_pkg::WORD_W-1:0]  ent_rdata_i,
  output      logic                         scr_we_o,
  output      logic [AW-1:0]                scr_waddr_o,
  output      logic [qrev_pkg::WORD_W-1:0]  scr_wdata_o,
  output      logic [AW-1:0]                scr_raddr_o,
  input  wire logic [qrev_pkg::WORD_W-1:0]  scr_rdata_i
);

  localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

  qrev_pkg::state_e state_q, state_d;
  logic [AW-1:0]    head_q, head_d;
  logic [AW-1:0]    tail_q, tail_d;
  logic             empty_q, empty_d;
  logic [AW:0]      k_q, k_d;
  logic [AW:0]      n_q, n_d;
  logic [AW:0]      k_m1;
  logic [AW:0]      n_m1;
  logic             accept;

  assign k_m1 = k_q - (AW+1)'(1);
  assign n_m1 = n_q - (AW+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qrev_pkg::S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
      k_q     <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
      k_q     <= k_d;
      n_q     <= n_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    empty_d      = empty_q;
    k_d          = k_q;
    n_d          = n_q;
    res_o.valid  = 1'b0;
    res_o.value  = '0;
    res_o.status = qrev_pkg::ST_DONE;
    ent_we_o     = 1'b0;
    ent_waddr_o  = tail_q + AW'(1);
    ent_wdata_o  = in_value_i;
    ent_raddr_o  = head_q;
    scr_we_o     = 1'b0;
    scr_waddr_o  = k_m1[AW-1:0];
    scr_wdata_o  = ent_rdata_i;
    scr_raddr_o  = k_q[AW-1:0];
    in_ready_o   = (state_q == qrev_pkg::S_IDLE) && out_free_i;
    accept       = in_valid_i && in_ready_o;

    case (state_q)
      qrev_pkg::S_IDLE: begin
        if (accept) begin
          case (in_cmd_i)
            qrev_pkg::CMD_ENQUEUE: begin
              res_o.valid = 1'b1;
              if (empty_q) begin
                ent_we_o    = 1'b1;
                ent_waddr_o = '0;
                head_d      = '0;
                tail_d      = '0;
                empty_d     = 1'b0;
              end else if (tail_q == LAST_SLOT) begin
                res_o.status = qrev_pkg::ST_FULL;
              end else begin
                ent_we_o = 1'b1;
                tail_d   = tail_q + AW'(1);
              end
            end
            qrev_pkg::CMD_DEQUEUE: begin
              if (empty_q) begin
                res_o.valid  = 1'b1;
                res_o.value  = '1;
                res_o.status = qrev_pkg::ST_EMPTY;
              end else begin
                state_d = qrev_pkg::S_DEQ;
                if (head_q >= tail_q) begin
                  head_d  = '0;
                  tail_d  = '0;
                  empty_d = 1'b1;
                end else begin
                  head_d = head_q + AW'(1);
                end
              end
            end
            qrev_pkg::CMD_REVERSE: begin
              if (empty_q) begin
                res_o.valid = 1'b1;
              end else begin
                n_d     = {1'b0, tail_q} - {1'b0, head_q} + (AW+1)'(1);
                k_d     = '0;
                state_d = qrev_pkg::S_REV_LOAD;
              end
            end
            default: begin
              res_o.valid = 1'b1;
            end
          endcase
        end
      end
      qrev_pkg::S_DEQ: begin
        res_o.valid = 1'b1;
        res_o.value = ent_rdata_i;
        state_d     = qrev_pkg::S_IDLE;
      end
      qrev_pkg::S_REV_LOAD: begin
        // read entries from the tail down, store them front to back
        ent_raddr_o = tail_q - k_q[AW-1:0];
        scr_we_o    = (k_q != '0);
        if (k_q == n_q) begin
          k_d     = '0;
          state_d = qrev_pkg::S_REV_STORE;
        end else begin
          k_d = k_q + (AW+1)'(1);
        end
      end
      qrev_pkg::S_REV_STORE: begin
        ent_we_o    = (k_q != '0);
        ent_waddr_o = k_m1[AW-1:0];
        ent_wdata_o = scr_rdata_i;
        if (k_q == n_q) begin
          head_d      = '0;
          tail_d      = n_m1[AW-1:0];
          k_d         = '0;
          res_o.valid = 1'b1;
          state_d     = qrev_pkg::S_IDLE;
        end else begin
          k_d = k_q + (AW+1)'(1);
        end
      end
      default: begin
        state_d = qrev_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/linear_queue_with_reverse.sv @@
// ----------------------------------------------------------------------------
// linear_queue_with_reverse
// Linear array queue of 32-bit words with enqueue, dequeue and reverse.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_axis channel (tuser = command, tdata = word),
//   one result per command leaves on the m_axis channel (tuser = status,
//   tdata = dequeued word, all ones on an empty dequeue, else zero).
//   Enqueue, refused commands and unused codes: result registered in the
//   cycle after acceptance; a new command can be taken every cycle while
//   the output register is free. Dequeue: the entry RAM read is registered,
//   so the result is formed in S_DEQ. Reverse: the live entries are copied
//   into a scratch RAM in reverse order, then back into slots 0 to count-1,
//   one word per cycle on each pass; an empty-queue reverse answers like an enqueue.
//   Reset empties the queue and both indices return to slot 0; no RAM clear.
//   A result waits in the output register while m_axis_tready_i is low, and
//   the next command is held off until that register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_queue_with_reverse #(
  parameter int unsigned QUEUE_DEPTH = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  wire logic [1:0]  s_axis_tuser_i,   // [1:0] command
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [31:0] m_axis_tdata_o,   // [31:0] result_value
  output      logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  qrev_pkg::res_t                res;
  logic                          out_free;
  logic                          out_valid_q;
  logic [qrev_pkg::WORD_W-1:0]   out_value_q;
  qrev_pkg::status_e             out_status_q;

  logic                          ent_we;
  logic [AW-1:0]                 ent_waddr;
  logic [qrev_pkg::WORD_W-1:0]   ent_wdata;
  logic [AW-1:0]                 ent_raddr;
  logic [qrev_pkg::WORD_W-1:0]   ent_rdata;
  logic                          scr_we;
  logic [AW-1:0]                 scr_waddr;
  logic [qrev_pkg::WORD_W-1:0]   scr_wdata;
  logic [AW-1:0]                 scr_raddr;
  logic [qrev_pkg::WORD_W-1:0]   scr_rdata;

  assign out_free = !out_valid_q || m_axis_tready_i;

  qrev_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_cmd_i    (s_axis_tuser_i),
    .in_value_i  (s_axis_tdata_i),
    .out_free_i  (out_free),
    .res_o       (res),
    .ent_we_o    (ent_we),
    .ent_waddr_o (ent_waddr),
    .ent_wdata_o (ent_wdata),
    .ent_raddr_o (ent_raddr),
    .ent_rdata_i (ent_rdata),
    .scr_we_o    (scr_we),
    .scr_waddr_o (scr_waddr),
    .scr_wdata_o (scr_wdata),
    .scr_raddr_o (scr_raddr),
    .scr_rdata_i (scr_rdata)
  );

  qrev_ram #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(qrev_pkg::WORD_W)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  qrev_ram #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(qrev_pkg::WORD_W)
  ) u_scratch (
    .clk_i   (clk_i),
    .we_i    (scr_we),
    .waddr_i (scr_waddr),
    .wdata_i (scr_wdata),
    .raddr_i (scr_raddr),
    .rdata_o (scr_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_value_q  <= res.value;
      out_status_q <= res.status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = out_status_q;

  a_res_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> out_free)
    else $error("result produced while output register occupied");

  a_enq_immediate : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == qrev_pkg::CMD_ENQUEUE))
      |-> res.valid)
    else $error("enqueue did not complete in its accept cycle");

  a_empty_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.valid && (res.status == qrev_pkg::ST_EMPTY)) |-> (res.value == '1))
    else $error("empty dequeue result is not all ones");

endmodule

`default_nettype wire
